// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// control bytes, colour codes, request and result layouts, cell store port.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);

    // field widths
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int IN_COL_W   = 7;
    localparam int IN_ROW_W   = 5;
    localparam int POS_W      = 11;
    localparam int BG_W       = 4;
    localparam int FG_W       = 4;
    localparam int CODE_W     = 10;
    localparam int CODE_MUL_W = 14;

    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(999);

    // control and escape bytes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_M        = 8'h6D;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // colour selection codes and their foregrounds
    localparam logic [CODE_W-1:0] SGR_RESET  = CODE_W'(0);
    localparam logic [CODE_W-1:0] SGR_RED    = CODE_W'(31);
    localparam logic [CODE_W-1:0] SGR_GREEN  = CODE_W'(32);
    localparam logic [CODE_W-1:0] SGR_YELLOW = CODE_W'(33);
    localparam logic [CODE_W-1:0] SGR_CYAN   = CODE_W'(36);

    localparam logic [FG_W-1:0] FG_DEFAULT = 4'hF;
    localparam logic [FG_W-1:0] FG_RED     = 4'h4;
    localparam logic [FG_W-1:0] FG_GREEN   = 4'h2;
    localparam logic [FG_W-1:0] FG_YELLOW  = 4'hE;
    localparam logic [FG_W-1:0] FG_CYAN    = 4'h3;

    typedef enum logic [1:0] {
        OP_STREAM = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // first member lands in the highest bits
    typedef struct packed {
        logic [IN_ROW_W-1:0] row;
        logic [IN_COL_W-1:0] column;
        logic [CHAR_W-1:0]   char_byte;
        t_op                 op;
    } t_req;

    typedef struct packed {
        logic [ATTR_W-1:0]   attribute;
        logic [POS_W-1:0]    cursor_pos;
        logic [IN_ROW_W-1:0] cursor_row;
        logic [IN_COL_W-1:0] cursor_col;
        logic [CHAR_W-1:0]   read_char;
    } t_res;

    localparam int REQ_W       = $bits(t_req);
    localparam int RES_W       = $bits(t_res);
    localparam int IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // cell store port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_cmd;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = '0;

endpackage
`default_nettype wire

// ===== sv/tcw_cell_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Character store of the screen: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_cell_ram (
    input  wire logic                      i_clk,
    input  wire tcw_pkg::t_ram_cmd         i_cmd,
    output logic [tcw_pkg::CHAR_W-1:0]     o_rdata
);

    logic [tcw_pkg::CHAR_W-1:0] r_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== sv/tcw_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_engine
// Sequencer of the console: escape parser, cursor tracking, positional access
// and the walker that clears, scrolls and blanks rows via the single cell port.
// ----------------------------------------------------------------------------
module tcw_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tcw_pkg::BG_W-1:0]    i_bg,
    input  wire logic                        i_req_valid,
    input  wire tcw_pkg::t_req               i_req,
    output logic                             o_req_ready,
    output logic                             o_res_valid,
    output tcw_pkg::t_res                    o_res,
    input  wire logic                        i_res_ready,
    output tcw_pkg::t_ram_cmd                o_ram_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  i_ram_rdata
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_STREAM,
        S_PRINT,
        S_SCROLL,
        S_BLANK,
        S_NEXT,
        S_POS,
        S_RDWAIT,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_DIGITS,
        ESC_SKIP
    } t_esc;

    t_state                          r_state, n_state;
    t_esc                            r_phase, n_phase;
    logic [tcw_pkg::CODE_W-1:0]      r_code, n_code;
    logic [tcw_pkg::COL_W-1:0]       r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]       r_line, n_line;
    logic [tcw_pkg::CNT_W-1:0]       r_lin, n_lin;
    logic [tcw_pkg::ATTR_W-1:0]      r_attr, n_attr;
    logic [tcw_pkg::CHAR_W-1:0]      r_ch, n_ch;
    logic [tcw_pkg::CHAR_W-1:0]      r_pch, n_pch;
    logic                            r_second, n_second;
    tcw_pkg::t_op                    r_op, n_op;
    logic [tcw_pkg::CNT_W-1:0]       r_addr, n_addr;
    logic                            r_inside, n_inside;
    logic [tcw_pkg::CHAR_W-1:0]      r_rd, n_rd;
    logic [tcw_pkg::CNT_W-1:0]       r_src, n_src;
    logic [tcw_pkg::CNT_W-1:0]       r_dst, n_dst;
    logic                            r_cp_v, n_cp_v;

    logic [tcw_pkg::CNT_W-1:0]       w_lin_dec;
    logic [tcw_pkg::CODE_MUL_W-1:0]  w_code_mul;
    logic [tcw_pkg::CODE_W-1:0]      w_code_sat;
    logic                            w_digit;
    logic                            w_src_live;

    assign w_lin_dec  = r_lin - 1'b1;
    assign w_digit    = (r_ch >= tcw_pkg::CH_DIGIT_LO) && (r_ch <= tcw_pkg::CH_DIGIT_HI);
    assign w_src_live = (r_src != tcw_pkg::CNT_W'(tcw_pkg::CELLS));

    // code * 10 + digit, saturating
    assign w_code_mul = (tcw_pkg::CODE_MUL_W'(r_code) << 3)
                      + (tcw_pkg::CODE_MUL_W'(r_code) << 1)
                      + tcw_pkg::CODE_MUL_W'(r_ch[3:0]);
    assign w_code_sat = (w_code_mul > tcw_pkg::CODE_MUL_W'(tcw_pkg::CODE_MAX))
                      ? tcw_pkg::CODE_MAX : tcw_pkg::CODE_W'(w_code_mul);

    // cell port
    always_comb begin
        o_ram_cmd = '0;
        unique case (r_state)
            S_CLEAR, S_BLANK: begin
                o_ram_cmd.we    = 1'b1;
                o_ram_cmd.waddr = r_dst[tcw_pkg::ADDR_W-1:0];
                o_ram_cmd.wdata = tcw_pkg::CH_SPACE;
            end
            S_PRINT: begin
                if (r_pch == tcw_pkg::CH_BS) begin
                    o_ram_cmd.we    = (r_col != '0);
                    o_ram_cmd.waddr = w_lin_dec[tcw_pkg::ADDR_W-1:0];
                    o_ram_cmd.wdata = tcw_pkg::CH_SPACE;
                end else begin
                    o_ram_cmd.we    = (r_pch != tcw_pkg::CH_LF);
                    o_ram_cmd.waddr = r_lin[tcw_pkg::ADDR_W-1:0];
                    o_ram_cmd.wdata = r_pch;
                end
            end
            S_SCROLL: begin
                // read one row below, write back the cell fetched last cycle
                o_ram_cmd.re    = w_src_live;
                o_ram_cmd.raddr = r_src[tcw_pkg::ADDR_W-1:0];
                o_ram_cmd.we    = r_cp_v;
                o_ram_cmd.waddr = r_dst[tcw_pkg::ADDR_W-1:0];
                o_ram_cmd.wdata = i_ram_rdata;
            end
            S_POS: begin
                o_ram_cmd.we    = r_inside && (r_op == tcw_pkg::OP_WRITE);
                o_ram_cmd.waddr = r_addr[tcw_pkg::ADDR_W-1:0];
                o_ram_cmd.wdata = r_ch;
                o_ram_cmd.re    = r_inside && (r_op == tcw_pkg::OP_READ);
                o_ram_cmd.raddr = r_addr[tcw_pkg::ADDR_W-1:0];
            end
            default: begin
                o_ram_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_code   = r_code;
        n_col    = r_col;
        n_line   = r_line;
        n_lin    = r_lin;
        n_attr   = r_attr;
        n_ch     = r_ch;
        n_pch    = r_pch;
        n_second = r_second;
        n_op     = r_op;
        n_addr   = r_addr;
        n_inside = r_inside;
        n_rd     = r_rd;
        n_src    = r_src;
        n_dst    = r_dst;
        n_cp_v   = r_cp_v;

        unique case (r_state)
            S_CLEAR: begin
                n_dst = r_dst + 1'b1;
                if (r_dst == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.op;
                    n_ch     = i_req.char_byte;
                    n_rd     = '0;
                    n_inside = (int'(i_req.column) < tcw_pkg::COLUMNS)
                            && (int'(i_req.row) < tcw_pkg::ROWS);
                    n_addr   = tcw_pkg::CNT_W'(i_req.row) * tcw_pkg::CNT_W'(tcw_pkg::COLUMNS)
                             + tcw_pkg::CNT_W'(i_req.column);
                    unique case (i_req.op)
                        tcw_pkg::OP_STREAM: n_state = S_STREAM;
                        tcw_pkg::OP_WRITE:  n_state = S_POS;
                        tcw_pkg::OP_READ:   n_state = S_POS;
                        default:            n_state = S_RESP;
                    endcase
                end
            end
            S_STREAM: begin
                n_state = S_RESP;
                unique case (r_phase)
                    ESC_IDLE: begin
                        if (r_ch == tcw_pkg::CH_ESC) begin
                            n_phase = ESC_SEEN;
                        end else begin
                            n_pch    = r_ch;
                            n_second = 1'b0;
                            n_state  = S_PRINT;
                        end
                    end
                    ESC_SEEN: begin
                        if (r_ch == tcw_pkg::CH_LBRACKET) begin
                            n_phase = ESC_DIGITS;
                            n_code  = '0;
                        end else begin
                            // held escape prints first, then this byte as if idle
                            n_phase  = ESC_IDLE;
                            n_pch    = tcw_pkg::CH_ESC;
                            n_second = 1'b1;
                            n_state  = S_PRINT;
                        end
                    end
                    ESC_DIGITS: begin
                        priority if (w_digit) begin
                            n_code = w_code_sat;
                        end else if (r_ch == tcw_pkg::CH_M) begin
                            n_phase = ESC_IDLE;
                            unique case (r_code)
                                tcw_pkg::SGR_RESET:  n_attr = {i_bg, tcw_pkg::FG_DEFAULT};
                                tcw_pkg::SGR_RED:    n_attr = {i_bg, tcw_pkg::FG_RED};
                                tcw_pkg::SGR_GREEN:  n_attr = {i_bg, tcw_pkg::FG_GREEN};
                                tcw_pkg::SGR_YELLOW: n_attr = {i_bg, tcw_pkg::FG_YELLOW};
                                tcw_pkg::SGR_CYAN:   n_attr = {i_bg, tcw_pkg::FG_CYAN};
                                default:             n_attr = r_attr;
                            endcase
                        end else begin
                            n_phase = ESC_SKIP;
                        end
                    end
                    default: begin
                        if (r_ch == tcw_pkg::CH_M) begin
                            n_phase = ESC_IDLE;
                        end
                    end
                endcase
            end
            S_PRINT: begin
                n_state = S_NEXT;
                if (r_pch == tcw_pkg::CH_BS) begin
                    if (r_col != '0) begin
                        n_col = r_col - 1'b1;
                        n_lin = w_lin_dec;
                    end
                end else if ((r_pch == tcw_pkg::CH_LF)
                          || (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1))) begin
                    n_col = '0;
                    if (r_line == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
                        n_lin   = tcw_pkg::CNT_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
                        n_src   = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                        n_dst   = '0;
                        n_cp_v  = 1'b0;
                        n_state = S_SCROLL;
                    end else begin
                        n_line = r_line + 1'b1;
                        n_lin  = (r_pch == tcw_pkg::CH_LF)
                               ? r_lin + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS)
                                 - tcw_pkg::CNT_W'(r_col)
                               : r_lin + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                    n_lin = r_lin + 1'b1;
                end
            end
            S_SCROLL: begin
                n_cp_v = w_src_live;
                if (w_src_live) begin
                    n_src = r_src + 1'b1;
                end
                if (r_cp_v) begin
                    n_dst = r_dst + 1'b1;
                end
                if (!w_src_live) begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                n_dst = r_dst + 1'b1;
                if (r_dst == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = S_RESP;
                if (r_second) begin
                    n_second = 1'b0;
                    if (r_ch == tcw_pkg::CH_ESC) begin
                        n_phase = ESC_SEEN;
                    end else begin
                        n_pch   = r_ch;
                        n_state = S_PRINT;
                    end
                end
            end
            S_POS: begin
                n_state = S_RESP;
                if (r_op == tcw_pkg::OP_READ) begin
                    if (r_inside) begin
                        n_state = S_RDWAIT;
                    end else begin
                        n_rd = tcw_pkg::CH_SPACE;
                    end
                end
            end
            S_RDWAIT: begin
                n_rd    = i_ram_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_phase  <= ESC_IDLE;
            r_code   <= '0;
            r_col    <= '0;
            r_line   <= '0;
            r_lin    <= '0;
            r_attr   <= tcw_pkg::ATTR_RESET;
            r_second <= 1'b0;
            r_dst    <= '0;
            r_cp_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_col    <= n_col;
            r_line   <= n_line;
            r_lin    <= n_lin;
            r_attr   <= n_attr;
            r_second <= n_second;
            r_dst    <= n_dst;
            r_cp_v   <= n_cp_v;
        end
        r_ch     <= n_ch;
        r_pch    <= n_pch;
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_inside <= n_inside;
        r_rd     <= n_rd;
        r_src    <= n_src;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);

    always_comb begin
        o_res.read_char  = r_rd;
        o_res.cursor_col = tcw_pkg::IN_COL_W'(r_col);
        o_res.cursor_row = tcw_pkg::IN_ROW_W'(r_line);
        o_res.cursor_pos = tcw_pkg::POS_W'(r_lin);
        o_res.attribute  = r_attr;
    end

endmodule
`default_nettype wire

// ===== sv/text_console_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text console over an 80x25 character store with a small colour escape set.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream (op, char_byte, column, row); each request
// gives exactly one result on the m_ stream (read_char, cursor and attribute).
// op 0 streams a byte through the escape parser onto the screen, op 1 writes
// a character at a position, op 2 reads one back, op 3 only reports state.
// The background colour register sits at APB address 0; write it while idle.
// Path from request to result: op 3 goes straight to the result; dropped escape
// bytes pass only the parser, and op 1 writes its cell; op 2 reads and waits for
// the registered read data (off the screen it answers a space with no read);
// printed bytes, newline and backspace pass the parser, print and advance, and
// a held escape adds a second print and advance. The next request is taken once
// the result moves to the output register. A byte that runs off the bottom row
// scrolls the store through its single read and write port, one cell per cycle.
// After reset the store is swept to spaces, during which s_tready stays low;
// configuration writes are taken meanwhile.
// One request is in flight at a time. The result sits in an output register,
// so the next request may be taken while the receiver stalls; the one after
// waits until that register drains.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // op[1:0], char_byte[9:2], column[16:10], row[21:17]
    input  wire logic [tcw_pkg::IN_TDATA_W-1:0]       s_tdata,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // read_char[7:0], cursor_col[14:8], cursor_row[19:15], cursor_pos[30:20],
    // attribute[38:31]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]           m_tdata,
    // register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tcw_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [tcw_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                      pready
);

    logic [tcw_pkg::BG_W-1:0]    r_bg;
    logic                        r_m_valid;
    tcw_pkg::t_res               r_m_data;

    tcw_pkg::t_req               w_req;
    tcw_pkg::t_res               w_res;
    logic                        w_res_valid;
    logic                        w_res_ready;
    tcw_pkg::t_ram_cmd           w_ram_cmd;
    logic [tcw_pkg::CHAR_W-1:0]  w_ram_rdata;
    logic [tcw_pkg::REG_IDX_W-1:0] w_reg_idx;

    assign w_reg_idx = paddr[tcw_pkg::APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= '0;
        end else if (psel && penable && pwrite && pready
                     && (w_reg_idx == tcw_pkg::REG_BACKGROUND)) begin
            r_bg <= pwdata[tcw_pkg::BG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == tcw_pkg::REG_BACKGROUND) begin
            prdata = tcw_pkg::APB_DATA_W'(r_bg);
        end
    end

    assign w_req = tcw_pkg::t_req'(s_tdata[tcw_pkg::REQ_W-1:0]);

    tcw_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bg        (r_bg),
        .i_req_valid (s_tvalid),
        .i_req       (w_req),
        .o_req_ready (s_tready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_ram_cmd   (w_ram_cmd),
        .i_ram_rdata (w_ram_rdata)
    );

    tcw_cell_ram u_cell_ram (
        .i_clk   (i_clk),
        .i_cmd   (w_ram_cmd),
        .o_rdata (w_ram_rdata)
    );

    // output register, refilled in the cycle it drains
    assign w_res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_m_data <= w_res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = tcw_pkg::OUT_TDATA_W'(r_m_data);

    // linear position as the result should carry it
    logic [tcw_pkg::POS_W-1:0] w_chk_pos;
    assign w_chk_pos = tcw_pkg::POS_W'(int'(r_m_data.cursor_row) * tcw_pkg::COLUMNS
                                       + int'(r_m_data.cursor_col));

    ap_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still in progress");

    ap_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((int'(r_m_data.cursor_col) < tcw_pkg::COLUMNS)
                   && (int'(r_m_data.cursor_row) < tcw_pkg::ROWS)))
        else $error("cursor outside the screen");

    ap_linear_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_m_data.cursor_pos == w_chk_pos))
        else $error("linear cursor position out of step with row and column");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. Requests go in on the s_
// stream with random gaps, and results come back on the m_ stream with random
// stalls. A shadow copy of the screen, cursor, attribute and escape parser
// predicts every result, and each result is compared field by field. The
// background register is set over APB between traffic phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    typedef enum int {
        ESC_IDLE,
        ESC_SEEN,
        ESC_DIGITS,
        ESC_SKIP
    } t_esc_phase;

    localparam logic [CHAR_W-1:0]   CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0]   CH_TILDE = 8'h7E;
    localparam logic [IN_COL_W-1:0] COL_LAST = IN_COL_W'(COLUMNS - 1);
    localparam logic [IN_ROW_W-1:0] ROW_LAST = IN_ROW_W'(ROWS - 1);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // shadow of the console
    logic [15:0]       shadow_cells [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] cur_attr;
    t_esc_phase        esc_phase;
    int                esc_code;
    logic [BG_W-1:0]   bg_colour;

    t_res        report_q [$];
    int unsigned items_sent;
    int unsigned scroll_count;
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          burst_mode;

    text_console_writer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog, budget grows with requests sent and scrolls predicted
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 30000 + 240 * items_sent + 8400 * scroll_count) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("[text_console_writer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // console prediction
    // ------------------------------------------------------------------
    function automatic void put_glyph(logic [CHAR_W-1:0] ch);
        int i;
        if (ch == CH_LF) begin
            cur_col = 0;
            cur_row++;
        end else if (ch == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
                shadow_cells[cur_row * COLUMNS + cur_col] = {cur_attr, CH_SPACE};
            end
        end else begin
            shadow_cells[cur_row * COLUMNS + cur_col] = {cur_attr, ch};
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                shadow_cells[i] = {cur_attr, CH_SPACE};
            cur_row = ROWS - 1;
            scroll_count++;
        end
    endfunction

    function automatic void take_plain_byte(logic [CHAR_W-1:0] ch);
        if (ch == CH_ESC)
            esc_phase = ESC_SEEN;
        else
            put_glyph(ch);
    endfunction

    function automatic void parse_stream_byte(logic [CHAR_W-1:0] ch);
        logic [FG_W-1:0] fg;
        logic            hit;
        case (esc_phase)
            ESC_SEEN: begin
                if (ch == CH_LBRACKET) begin
                    esc_phase = ESC_DIGITS;
                    esc_code  = 0;
                end else begin
                    // the held escape lands on screen first
                    esc_phase = ESC_IDLE;
                    put_glyph(CH_ESC);
                    take_plain_byte(ch);
                end
            end
            ESC_DIGITS: begin
                if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) begin
                    esc_code = esc_code * 10 + int'(ch - CH_DIGIT_LO);
                    if (esc_code > CODE_MAX)
                        esc_code = CODE_MAX;
                end else if (ch == CH_M) begin
                    hit = 1'b1;
                    fg  = FG_DEFAULT;
                    case (esc_code)
                        SGR_RESET:  fg = FG_DEFAULT;
                        SGR_RED:    fg = FG_RED;
                        SGR_GREEN:  fg = FG_GREEN;
                        SGR_YELLOW: fg = FG_YELLOW;
                        SGR_CYAN:   fg = FG_CYAN;
                        default:    hit = 1'b0;
                    endcase
                    if (hit)
                        cur_attr = {bg_colour, fg};
                    esc_phase = ESC_IDLE;
                end else begin
                    esc_phase = ESC_SKIP;
                end
            end
            ESC_SKIP: begin
                if (ch == CH_M)
                    esc_phase = ESC_IDLE;
            end
            default: take_plain_byte(ch);
        endcase
    endfunction

    function automatic t_res console_apply(t_req req);
        t_res              res;
        logic              in_screen;
        logic [CHAR_W-1:0] rd;
        int                idx;
        in_screen = (req.column < COLUMNS) && (req.row < ROWS);
        idx       = req.row * COLUMNS + req.column;
        rd        = '0;
        case (req.op)
            OP_STREAM: parse_stream_byte(req.char_byte);
            OP_WRITE: begin
                if (in_screen)
                    shadow_cells[idx] = {cur_attr, req.char_byte};
            end
            OP_READ:   rd = in_screen ? shadow_cells[idx][CHAR_W-1:0] : CH_SPACE;
            default: ;
        endcase
        res.read_char  = rd;
        res.cursor_col = IN_COL_W'(cur_col);
        res.cursor_row = IN_ROW_W'(cur_row);
        res.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
        res.attribute  = cur_attr;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial begin : result_sink
        int unsigned stall;
        t_res        got;
        t_res        want;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            got = t_res'(m_tdata[RES_W-1:0]);
            if (report_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = report_q.pop_front();
                check_field("read_char", want.read_char, got.read_char);
                check_field("cursor_col", want.cursor_col, got.cursor_col);
                check_field("cursor_row", want.cursor_row, got.cursor_row);
                check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
                check_field("attribute", want.attribute, got.attribute);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_req(t_op op, logic [CHAR_W-1:0] ch, logic [IN_COL_W-1:0] col,
                            logic [IN_ROW_W-1:0] row);
        t_req        req;
        int unsigned gap;
        req.op        = op;
        req.char_byte = ch;
        req.column    = col;
        req.row       = row;
        gap = burst_mode ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(req);
        do @(posedge i_clk); while (s_tready !== 1'b1);
        report_q.push_back(console_apply(req));
        items_sent++;
    endtask

    // position fields are don't-care for a stream byte, so they stay random
    task automatic stream_byte(logic [CHAR_W-1:0] ch);
        send_req(OP_STREAM, ch, IN_COL_W'($urandom_range(0, 127)),
                 IN_ROW_W'($urandom_range(0, 31)));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_background(logic [BG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BACKGROUND, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        bg_colour = value;
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(value)) begin
            $display("%0t background readback mismatch: expected %h, actual %h",
                     $time, APB_DATA_W'(value), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_register_access();
        // taken during the clearing sweep after reset
        set_background(BG_W'($urandom_range(1, 14)));
        set_background('0);
    endtask

    task automatic test_directed_cases();
        send_req(OP_NOP, 8'hFF, 7'h7F, 5'h1F);
        send_req(OP_READ, 8'h00, 7'h7F, 5'h1F);
        send_req(OP_READ, 8'hFF, COL_LAST, ROW_LAST);
        send_req(OP_WRITE, 8'hFF, COL_LAST, ROW_LAST);
        send_req(OP_WRITE, 8'h41, IN_COL_W'(COLUMNS), '0);
        send_req(OP_WRITE, 8'h41, '0, IN_ROW_W'(ROWS));
        send_req(OP_READ, 8'h00, COL_LAST, ROW_LAST);
        // backspace with the cursor in column zero
        stream_byte(CH_BS);
        stream_byte(8'h00);
        stream_byte(8'h41);
        stream_byte(CH_BS);
        send_req(OP_READ, 8'h00, 7'd1, 5'd0);
        stream_byte(CH_ESC);
        stream_byte(CH_LBRACKET);
        stream_byte(CH_DIGIT_LO + 8'd3);
        stream_byte(CH_DIGIT_LO + 8'd1);
        stream_byte(CH_M);
        // escape not followed by a bracket prints as a glyph
        stream_byte(CH_ESC);
        stream_byte(8'h78);
        // malformed sequence is skipped through the terminator
        stream_byte(CH_ESC);
        stream_byte(CH_LBRACKET);
        stream_byte(CH_SEMI);
        stream_byte(CH_M);
        stream_byte(CH_LF);
    endtask

    task automatic send_colour_escape();
        int unsigned form;
        int unsigned pick;
        int unsigned code;
        int unsigned i;
        string       digits;
        logic [CHAR_W-1:0] b;
        form = $urandom_range(0, 9);
        stream_byte(CH_ESC);
        if (form == 7) begin
            b = CHAR_W'($urandom_range(0, 255));
            if (b == CH_LBRACKET)
                b = CH_SPACE;
            stream_byte(b);
        end else begin
            stream_byte(CH_LBRACKET);
            pick = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0: code = SGR_RESET;
                1: code = SGR_RED;
                2: code = SGR_GREEN;
                3: code = SGR_YELLOW;
                default: code = SGR_CYAN;
            endcase
            if (pick == 6)
                code = $urandom_range(0, 99);
            else if (pick == 7)
                code = $urandom_range(0, 99999);   // pushes the code into saturation
            digits = (pick == 8) ? "" : $sformatf("%0d", code);
            if (pick != 8 && $urandom_range(0, 3) == 0)
                digits = {"0", digits};
            for (i = 0; i < digits.len(); i++)
                stream_byte(digits[i]);
            if (form == 8) begin
                b = CHAR_W'($urandom_range(0, 255));
                if ((b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) || b == CH_M)
                    b = CH_SEMI;
                stream_byte(b);
                repeat ($urandom_range(0, 3)) stream_byte(CHAR_W'($urandom_range(0, 255)));
                stream_byte(CH_M);
            end else if (form != 9) begin
                stream_byte(CH_M);
            end
            // form 9 leaves the sequence open for whatever follows
        end
    endtask

    task automatic run_console_traffic(int unsigned count);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned n;
        logic [CHAR_W-1:0]   b;
        logic [IN_COL_W-1:0] col;
        logic [IN_ROW_W-1:0] row;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            burst_mode = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            col  = ($urandom_range(0, 6) == 0) ? IN_COL_W'($urandom_range(0, 127))
                                               : IN_COL_W'($urandom_range(0, COLUMNS - 1));
            row  = ($urandom_range(0, 6) == 0) ? IN_ROW_W'($urandom_range(0, 31))
                                               : IN_ROW_W'($urandom_range(0, ROWS - 1));
            if (kind < 30) begin
                n = $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(0, 6) == 0)
                        b = CHAR_W'($urandom_range(0, 255));
                    else
                        b = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
                    stream_byte(b);
                end
            end else if (kind < 46) begin
                send_colour_escape();
            end else if (kind < 54) begin
                if ($urandom_range(0, 1) == 0)
                    repeat ($urandom_range(1, 2)) stream_byte(CH_LF);
                else
                    repeat ($urandom_range(1, 5)) stream_byte(CH_BS);
            end else if (kind < 78) begin
                send_req(OP_WRITE, CHAR_W'($urandom_range(0, 255)), col, row);
            end else if (kind < 94) begin
                send_req(OP_READ, CHAR_W'($urandom_range(0, 255)), col, row);
            end else begin
                send_req(t_op'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                         IN_COL_W'($urandom_range(0, 127)), IN_ROW_W'($urandom_range(0, 31)));
            end
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        logic [BG_W-1:0] bg;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: bg = '1;
                2: bg = '0;
                default: bg = BG_W'($urandom_range(1, 14));
            endcase
            // sender holds off until every result is back
            wait_drain();
            set_background(bg);
            run_console_traffic(290);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int i;
        for (i = 0; i < CELLS; i++)
            shadow_cells[i] = {ATTR_RESET, CH_SPACE};
        cur_col      = 0;
        cur_row      = 0;
        cur_attr     = ATTR_RESET;
        esc_phase    = ESC_IDLE;
        esc_code     = 0;
        bg_colour    = '0;
        items_sent   = 0;
        scroll_count = 0;
        fail_count   = 0;
        cycle_count  = 0;
        burst_mode   = 1'b0;

        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_directed_cases();
        test_random_traffic();

        wait_drain();
        repeat (2100) @(posedge i_clk);
        $display("covered %0d requests with %0d scrolls: text, colour escapes, cell access",
                 items_sent, scroll_count);
        $display("background register set to both extremes and random values, read back");
        if (fail_count == 0)
            $display("[text_console_writer] OK");
        else
            $display("[text_console_writer] ERROR");
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_engine.sv
sv/text_console_writer.sv
test/tb_top.sv
